### design/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared constants and types for the HSL colorize pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

  // default channel width, unsigned Q0.C
  localparam int unsigned CHANNEL_BITS_DEF = 16;

  // Rec.709 luminance weights, Q0.16, summing to 65536
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  // rounding offset for the >>16 of the weighted sum
  localparam logic [15:0] W_HALF  = 16'd32768;

  // saturation reset value before truncation to the channel width
  localparam logic [31:0] SAT_RESET = 32'd32768;

  // register stages from input word to output word
  localparam int unsigned PIPE_DEPTH = 11;

  // configuration register index
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HUE   = 2'd0,
    CFG_SAT   = 2'd1,
    CFG_LIGHT = 2'd2
  } hsl_cfg_idx_e;

  // hue sextant class for one output channel
  typedef enum logic [1:0] {
    SEG_RISE,  // m1 ramping up to m2
    SEG_HIGH,  // flat at m2
    SEG_FALL,  // m2 ramping down to m1
    SEG_LOW    // flat at m1
  } hsl_seg_e;

endpackage

`default_nettype wire

### design/hsl_cfg.sv
// ----------------------------------------------------------------------------
// hsl_cfg
// Configuration registers and the per-frame values derived from them:
// lightness gain and bias, and the hue sextant and ramp weight per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_cfg #(
  parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              we_i,
  input  wire logic [hsl_pkg::CFG_IDX_BITS-1:0]  idx_i,
  input  wire logic [CHANNEL_BITS:0]             data_i,
  output logic      [CHANNEL_BITS-1:0]           sat_o,
  output logic                                   sat_zero_o,
  output logic      [CHANNEL_BITS-1:0]           gain_o,
  output logic      [CHANNEL_BITS-1:0]           bias_o,
  output hsl_pkg::hsl_seg_e                      seg_o [3],
  output logic      [CHANNEL_BITS:0]             w_o   [3]
);

  localparam int unsigned C = CHANNEL_BITS;
  localparam int unsigned HW = C + 4;
  localparam logic [C-1:0]  ONE     = '1;
  localparam logic [C-1:0]  SAT_RST = hsl_pkg::SAT_RESET[C-1:0];
  localparam logic [HW-1:0] TURN    = HW'(1) << C;
  localparam logic [HW-1:0] TURN_X3 = HW'(3) << C;
  localparam logic [HW-1:0] TURN_X6 = HW'(6) << C;

  logic [C-1:0] hue_q;
  logic [C-1:0] sat_q;
  logic [C:0]   light_q;

  // register writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q   <= '0;
      sat_q   <= SAT_RST;
      light_q <= '0;
    end else if (we_i) begin
      case (idx_i)
        hsl_pkg::CFG_HUE:   hue_q   <= data_i[C-1:0];
        hsl_pkg::CFG_SAT:   sat_q   <= data_i[C-1:0];
        hsl_pkg::CFG_LIGHT: light_q <= data_i;
        default: ;
      endcase
    end
  end

  // lightness: magnitude clamped to one, gain = one - |L|, bias = L when positive
  logic [C:0]   mag;
  logic [C-1:0] gain_d;
  logic [C-1:0] bias_d;

  always_comb begin
    mag = light_q[C] ? (~light_q + (C+1)'(1)) : light_q;
    if (mag[C]) mag = {1'b0, ONE};
    gain_d = ONE - mag[C-1:0];
    bias_d = light_q[C] ? '0 : mag[C-1:0];
  end

  // hue times six, then offset by +1/3 turn (red) and +2/3 turn (blue)
  logic [HW-1:0]     h6;
  logic [HW-1:0]     hh    [3];
  hsl_pkg::hsl_seg_e seg_d [3];
  logic [C:0]        w_d   [3];
  logic [HW-1:0]     fall;

  always_comb begin
    fall = '0;
    h6 = (HW'(hue_q) << 2) + (HW'(hue_q) << 1);
    hh[0] = h6 + (TURN << 1);
    if (hh[0] >= TURN_X6) hh[0] = hh[0] - TURN_X6;
    hh[1] = h6;
    hh[2] = h6 + (TURN << 2);
    if (hh[2] >= TURN_X6) hh[2] = hh[2] - TURN_X6;
    for (int i = 0; i < 3; i++) begin
      fall = (TURN << 2) - hh[i];
      if (hh[i] < TURN) begin
        seg_d[i] = hsl_pkg::SEG_RISE;
        w_d[i]   = hh[i][C:0];
      end else if (hh[i] < TURN_X3) begin
        seg_d[i] = hsl_pkg::SEG_HIGH;
        w_d[i]   = '0;
      end else if (hh[i] < (TURN << 2)) begin
        seg_d[i] = hsl_pkg::SEG_FALL;
        w_d[i]   = fall[C:0];
      end else begin
        seg_d[i] = hsl_pkg::SEG_LOW;
        w_d[i]   = '0;
      end
    end
  end

  // derived values are registered, following the registers in the next cycle
  logic [C-1:0]      gain_q;
  logic [C-1:0]      bias_q;
  logic              sat_zero_q;
  hsl_pkg::hsl_seg_e seg_q [3];
  logic [C:0]        w_q   [3];

  always_ff @(posedge clk_i) begin
    gain_q     <= gain_d;
    bias_q     <= bias_d;
    sat_zero_q <= (sat_q == '0);
    for (int i = 0; i < 3; i++) begin
      seg_q[i] <= seg_d[i];
      w_q[i]   <= w_d[i];
    end
  end

  assign sat_o      = sat_q;
  assign sat_zero_o = sat_zero_q;
  assign gain_o     = gain_q;
  assign bias_o     = bias_q;
  assign seg_o      = seg_q;
  assign w_o        = w_q;

endmodule

`default_nettype wire

### design/hsl_luma.sv
// ----------------------------------------------------------------------------
// hsl_luma
// Two-stage Rec.709 luminance: weighted products, then rounded sum and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_luma #(
  parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic [1:0]              en_i,
  input  wire logic [CHANNEL_BITS-1:0] red_i,
  input  wire logic [CHANNEL_BITS-1:0] green_i,
  input  wire logic [CHANNEL_BITS-1:0] blue_i,
  output logic      [CHANNEL_BITS-1:0] lum_o
);

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned PW = C + 16;
  localparam int unsigned SW = C + 18;
  localparam logic [C-1:0] ONE = '1;

  logic [PW-1:0] pr_q, pg_q, pb_q;
  logic [SW-1:0] sum;
  logic [C+1:0]  lum_full;
  logic [C-1:0]  lum_q;

  // stage 1: constant-weight products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pr_q <= PW'(red_i)   * PW'(hsl_pkg::W_RED);
      pg_q <= PW'(green_i) * PW'(hsl_pkg::W_GREEN);
      pb_q <= PW'(blue_i)  * PW'(hsl_pkg::W_BLUE);
    end
  end

  // stage 2: round half up, drop the Q0.16 weight scale, clamp
  always_comb begin
    sum      = SW'(pr_q) + SW'(pg_q) + SW'(pb_q) + SW'(hsl_pkg::W_HALF);
    lum_full = sum[SW-1:16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) lum_q <= (lum_full > (C+2)'(ONE)) ? ONE : lum_full[C-1:0];
  end

  assign lum_o = lum_q;

endmodule

`default_nettype wire

### design/hsl_mulu.sv
// ----------------------------------------------------------------------------
// hsl_mulu
// Two-stage unit multiply: q = (a*b + one/2) / one, one = 2^C - 1.
// The divide by 2^C - 1 is (x + (x >> C) + 1) >> C, exact while q < 2^C.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_mulu #(
  parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned B_BITS       = hsl_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic [1:0]              en_i,
  input  wire logic [CHANNEL_BITS-1:0] a_i,
  input  wire logic [B_BITS-1:0]       b_i,
  output logic      [CHANNEL_BITS-1:0] q_o
);

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned P  = C + B_BITS;
  localparam int unsigned XW = P + 2;
  localparam logic [C-1:0] ONE = '1;

  logic [P-1:0]  prod_q;
  logic [XW-1:0] x;
  logic [XW-1:0] qsum;
  logic [C-1:0]  q_q;

  // stage 1: product
  always_ff @(posedge clk_i) begin
    if (en_i[0]) prod_q <= P'(a_i) * P'(b_i);
  end

  // stage 2: rounded divide by one
  always_comb begin
    x    = XW'(prod_q) + XW'(ONE >> 1);
    qsum = x + (x >> C) + XW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) q_q <= qsum[C +: C];
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

### design/hsl_sext.sv
// ----------------------------------------------------------------------------
// hsl_sext
// One output channel of the HSL-to-RGB step: ramp product, then sextant
// select between ramp, m1 and m2, with the gray bypass for zero saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_sext #(
  parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic [1:0]              en_i,
  input  wire hsl_pkg::hsl_seg_e       seg_i,
  input  wire logic [CHANNEL_BITS:0]   w_i,
  input  wire logic [CHANNEL_BITS-1:0] d_i,
  input  wire logic [CHANNEL_BITS-1:0] m1_i,
  input  wire logic [CHANNEL_BITS-1:0] m2_i,
  input  wire logic [CHANNEL_BITS-1:0] lum_i,
  input  wire logic                    gray_i,
  output logic      [CHANNEL_BITS-1:0] out_o
);

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned PW = 2 * C + 1;
  localparam int unsigned RW = PW + 1;
  localparam logic [C-1:0] ONE = '1;

  logic [PW-1:0] prod_q;
  logic [RW-1:0] rsum;
  logic [C+1:0]  ramp;
  logic [C-1:0]  out_d;
  logic [C-1:0]  out_q;

  // stage 1: (m2 - m1) times the position inside the sextant
  always_ff @(posedge clk_i) begin
    if (en_i[0]) prod_q <= PW'(d_i) * PW'(w_i);
  end

  // stage 2: m1 + rounded ramp, clamped, then sextant select
  always_comb begin
    rsum = RW'(prod_q) + (RW'(1) << (C - 1));
    ramp = (C+2)'(m1_i) + (C+2)'(rsum >> C);
    if (ramp > (C+2)'(ONE)) ramp = (C+2)'(ONE);
    case (seg_i)
      hsl_pkg::SEG_RISE,
      hsl_pkg::SEG_FALL: out_d = ramp[C-1:0];
      hsl_pkg::SEG_HIGH: out_d = m2_i;
      hsl_pkg::SEG_LOW:  out_d = m1_i;
      default:           out_d = m1_i;
    endcase
    if (gray_i) out_d = lum_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

### design/hsl_colorize_pixel.sv
// ----------------------------------------------------------------------------
// hsl_colorize_pixel
// Colorize an RGBA pixel stream to a fixed hue and saturation with a
// lightness shift applied to each pixel's Rec.709 luminance.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while the output is not stalled, through 11
// register stages. The two pipelined unit multipliers (lightness, then m2)
// each split into a multiply stage and a divide-by-one stage, and the
// per-channel ramp multipliers into a multiply and a round-and-select stage.
// Every stage holds its own valid bit and stalls only when the stage after it
// is full, so the input keeps flowing into empty stages while a result waits
// on the output. The user must write registers through cfg_we_i/cfg_idx_i/
// cfg_data_i only while the stream is idle; the block does not enforce this.
// Derived values are registered and settle in the cycle after a write.
`default_nettype none

module hsl_colorize_pixel #(
  parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF,
  localparam int unsigned DATA_BITS   = ((4 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [hsl_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CHANNEL_BITS:0]             cfg_data_i,
  // input pixel stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [DATA_BITS-1:0]              s_axis_tdata,  // in_red, in_green,
                                                                // in_blue, in_alpha
  input  wire logic                              s_axis_tlast,  // in_last
  // output pixel stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [DATA_BITS-1:0]              m_axis_tdata,  // out_red, out_green,
                                                                // out_blue, out_alpha
  output logic                                   m_axis_tlast   // out_last
);

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned NS = hsl_pkg::PIPE_DEPTH;
  localparam logic [C-1:0] ONE = '1;

  // input word unpack
  logic [C-1:0] in_red, in_green, in_blue, in_alpha;
  assign in_red   = s_axis_tdata[0 * C +: C];
  assign in_green = s_axis_tdata[1 * C +: C];
  assign in_blue  = s_axis_tdata[2 * C +: C];
  assign in_alpha = s_axis_tdata[3 * C +: C];

  // stage valids and per-stage enables: a stage loads when empty or draining
  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !valid_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !valid_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NS-1];

  // alpha and last ride along with the pixel
  logic [C-1:0] alpha_q [NS];
  logic         last_q  [NS];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      alpha_q[0] <= in_alpha;
      last_q[0]  <= s_axis_tlast;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        alpha_q[k] <= alpha_q[k-1];
        last_q[k]  <= last_q[k-1];
      end
    end
  end

  // configuration
  logic [C-1:0]      sat, gain, bias;
  logic              sat_zero;
  hsl_pkg::hsl_seg_e seg [3];
  logic [C:0]        wgt [3];

  hsl_cfg #(.CHANNEL_BITS(C)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (cfg_we_i),
    .idx_i      (cfg_idx_i),
    .data_i     (cfg_data_i),
    .sat_o      (sat),
    .sat_zero_o (sat_zero),
    .gain_o     (gain),
    .bias_o     (bias),
    .seg_o      (seg),
    .w_o        (wgt)
  );

  // stages 0-1: luminance
  logic [C-1:0] lum;

  hsl_luma #(.CHANNEL_BITS(C)) u_luma (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .red_i   (in_red),
    .green_i (in_green),
    .blue_i  (in_blue),
    .lum_o   (lum)
  );

  // stages 2-3: lum * gain / one
  logic [C-1:0] q1;

  hsl_mulu #(.CHANNEL_BITS(C), .B_BITS(C)) u_mul_light (
    .clk_i (clk_i),
    .en_i  (en[3:2]),
    .a_i   (lum),
    .b_i   (gain),
    .q_o   (q1)
  );

  // stage 4: add lightness bias, clamp; adjusted luminance carried to the end
  logic [C:0]   lum2_sum;
  logic [C-1:0] lum_q [4:9];

  assign lum2_sum = (C+1)'(q1) + (C+1)'(bias);

  always_ff @(posedge clk_i) begin
    if (en[4]) lum_q[4] <= lum2_sum[C] ? ONE : lum2_sum[C-1:0];
    for (int k = 5; k <= 9; k++) begin
      if (en[k]) lum_q[k] <= lum_q[k-1];
    end
  end

  // stages 5-6: m2 product, lower half l*(1+s), upper half l + s*(1-l)
  logic         lo_half;
  logic [C-1:0] m2_a;
  logic [C:0]   m2_b;
  logic [C-1:0] q2;
  logic [C-1:0] addm_q [5:6];

  always_comb begin
    lo_half = ({lum_q[4], 1'b0} <= (C+1)'(ONE));
    m2_a    = lo_half ? lum_q[4] : sat;
    m2_b    = lo_half ? ((C+1)'(ONE) + (C+1)'(sat)) : (C+1)'(ONE - lum_q[4]);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) addm_q[5] <= lo_half ? '0 : lum_q[4];
    if (en[6]) addm_q[6] <= addm_q[5];
  end

  hsl_mulu #(.CHANNEL_BITS(C), .B_BITS(C + 1)) u_mul_m2 (
    .clk_i (clk_i),
    .en_i  (en[6:5]),
    .a_i   (m2_a),
    .b_i   (m2_b),
    .q_o   (q2)
  );

  // stage 7: m2 clamp
  logic [C:0]   m2_sum;
  logic [C-1:0] m2_q [7:9];

  assign m2_sum = (C+1)'(q2) + (C+1)'(addm_q[6]);

  // stage 8: m1 = 2l - m2 clamped, ramp height d = m2 - m1 (never negative)
  logic [C:0]   two_lum;
  logic [C:0]   m1_diff;
  logic [C-1:0] m1_d;
  logic [C-1:0] m1_q [8:9];
  logic [C-1:0] d_q;

  always_comb begin
    two_lum = {lum_q[7], 1'b0};
    m1_diff = two_lum - (C+1)'(m2_q[7]);
    if (two_lum <= (C+1)'(m2_q[7]))   m1_d = '0;
    else if (m1_diff > (C+1)'(ONE))   m1_d = ONE;
    else                              m1_d = m1_diff[C-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) m2_q[7] <= m2_sum[C] ? ONE : m2_sum[C-1:0];
    if (en[8]) begin
      m2_q[8] <= m2_q[7];
      m1_q[8] <= m1_d;
      d_q     <= m2_q[7] - m1_d;
    end
    if (en[9]) begin
      m2_q[9] <= m2_q[8];
      m1_q[9] <= m1_q[8];
    end
  end

  // stages 9-10: per-channel sextant, lane 0 red, 1 green, 2 blue
  logic [C-1:0] chan [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    hsl_sext #(.CHANNEL_BITS(C)) u_sext (
      .clk_i  (clk_i),
      .en_i   (en[10:9]),
      .seg_i  (seg[i]),
      .w_i    (wgt[i]),
      .d_i    (d_q),
      .m1_i   (m1_q[9]),
      .m2_i   (m2_q[9]),
      .lum_i  (lum_q[9]),
      .gray_i (sat_zero),
      .out_o  (chan[i])
    );
  end

  // output word pack, zero padded
  assign m_axis_tdata = DATA_BITS'({alpha_q[NS-1], chan[2], chan[1], chan[0]});
  assign m_axis_tlast = last_q[NS-1];

endmodule

`default_nettype wire

### design/hsl_checker.sv
// ----------------------------------------------------------------------------
// hsl_checker
// Port-level checks for the colorize pipeline: output hold under stall,
// words in flight against pipeline depth, and input readiness.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_checker #(
  parameter int unsigned DATA_BITS = 64
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [DATA_BITS-1:0] m_axis_tdata,
  input wire logic                 m_axis_tlast
);

  localparam int unsigned DEPTH = hsl_pkg::PIPE_DEPTH;
  localparam int unsigned CW    = $clog2(DEPTH + 2);

  // words accepted but not yet delivered
  logic [CW-1:0] cnt_q;
  logic          acc_in, acc_out;

  assign acc_in  = s_axis_tvalid && s_axis_tready;
  assign acc_out = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CW'(acc_in) - CW'(acc_out);
    end
  end

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output stage empty");

  // no result without a word in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("output word with nothing in flight");

  // a full, stalled pipeline takes nothing more
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CW'(DEPTH)) && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted into a full stalled pipeline");

endmodule

bind hsl_colorize_pixel hsl_checker #(.DATA_BITS(DATA_BITS)) u_hsl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
